// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ALS_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ALS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== src/als_pkg.sv =====
`timescale 1ns / 1ps

package als_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_SHOW  = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_LATCH = 2'd3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 3'd5;

  localparam logic [4:0] LAST_BIT = 5'd23;

  typedef logic [23:0] color_t;

  typedef struct packed {
    logic line_level;
    logic busy;
  } result_t;

  // stored order is red, green, blue; wire order is green, red, blue
  function automatic color_t to_wire(input color_t c);
    return {c[15:8], c[23:16], c[7:0]};
  endfunction

  function automatic logic [7:0] at_least_one8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

// ===== src/als_frame_mem.sv =====
`timescale 1ns / 1ps

module als_frame_mem #(
  parameter int MAX_LEDS = 64,
  parameter int AW = 6
) (
  input  logic            clk,
  input  logic            rst,
  output logic            clr_busy,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  als_pkg::color_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output als_pkg::color_t rd_data
);
  import als_pkg::*;

  color_t        mem [MAX_LEDS];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(MAX_LEDS - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/als_out_buf.sv =====
`timescale 1ns / 1ps

module als_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  als_pkg::result_t push_data,
  output logic             push_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output als_pkg::result_t out_data
);
  import als_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop        = out_valid && out_ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/addressable_led_serializer.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Frame buffer and one-wire LED serializer.
// Input channel (in_valid/in_ready) carries one word per action: tick,
// write one LED color, or show. Output channel (out_valid/out_ready)
// returns one word per accepted input: the line level and busy flag after
// that action. A new word can be taken every cycle while in_ready is high,
// and its result is registered in the output buffer when it is accepted.
// A two-entry output buffer lets one more word in while a result waits;
// with two results waiting, in_ready drops until the receiver takes one.
// Configuration is a plain write port (cfg_wen, cfg_index, cfg_data).
// Colors sit in a MAX_LEDS-entry memory; the next LED's color is read one
// LED ahead and LED 0 is mirrored in a register so a show starts at once.
// After reset the memory is cleared one entry per cycle with in_ready low;
// configuration writes are taken during that pass.
// Sustained rate: one word per cycle while in_ready is high, set by the
// single update of the phase counter per word.
module addressable_led_serializer #(
  parameter int MAX_LEDS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     action,
  input  logic [5:0]                     led_index,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           line_level,
  output logic                           busy_res,
  input  logic                           cfg_wen,
  input  logic [als_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [als_pkg::CFG_DATA_W-1:0] cfg_data
);
  import als_pkg::*;

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int LW = $clog2(MAX_LEDS + 1);

  logic [7:0]  one_high_ticks, one_low_ticks, zero_high_ticks, zero_low_ticks;
  logic [15:0] latch_ticks;
  logic [6:0]  led_count;

  logic [1:0]    phase, phase_next;
  logic [AW-1:0] led_pos, led_pos_next;
  logic [4:0]    bit_pos, bit_pos_next;
  logic [15:0]   cnt, cnt_next;
  logic          line_reg, line_reg_next;
  color_t        cur_word, cur_word_next;
  color_t        led0_word;

  logic          clr_busy;
  logic          mem_we;
  logic [AW-1:0] rd_addr;
  color_t        next_color;
  logic          buf_ready;
  logic          acc;
  result_t       res_in, res_out;

  logic [6:0]    count_c;
  logic [LW-1:0] frame_leds;
  logic [LW:0]   next_pos_ext;
  logic          cur_bit, next_bit, show_bit, adv_bit;
  color_t        led0_wire, next_wire;

  assign in_ready = !clr_busy && buf_ready;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high_ticks  <= 8'd11;
      one_low_ticks   <= 8'd6;
      zero_high_ticks <= 8'd5;
      zero_low_ticks  <= 8'd12;
      latch_ticks     <= 16'd960;
      led_count       <= 7'd64;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_ONE_HIGH:  one_high_ticks  <= cfg_data[7:0];
        REG_ONE_LOW:   one_low_ticks   <= cfg_data[7:0];
        REG_ZERO_HIGH: zero_high_ticks <= cfg_data[7:0];
        REG_ZERO_LOW:  zero_low_ticks  <= cfg_data[7:0];
        REG_LATCH:     latch_ticks     <= cfg_data;
        REG_LED_COUNT: led_count       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign count_c      = (led_count == 7'd0) ? 7'd1 : led_count;
  assign frame_leds   = (32'(count_c) > MAX_LEDS) ? LW'(MAX_LEDS) : LW'(count_c);
  assign next_pos_ext = (LW + 1)'(led_pos) + 1'b1;
  assign rd_addr      = (next_pos_ext < (LW + 1)'(MAX_LEDS)) ? AW'(next_pos_ext) : '0;

  assign mem_we = acc && (action == ACT_WRITE) && (phase == PH_IDLE) &&
                  (32'(led_index) < MAX_LEDS);

  als_frame_mem #(
    .MAX_LEDS(MAX_LEDS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .rst(rst),
    .clr_busy(clr_busy),
    .wr_en(mem_we),
    .wr_addr(AW'(led_index)),
    .wr_data({red, green, blue}),
    .rd_addr(rd_addr),
    .rd_data(next_color)
  );

  assign led0_wire = to_wire(led0_word);
  assign next_wire = to_wire(next_color);
  assign cur_bit   = cur_word[5'(LAST_BIT - bit_pos)];
  assign next_bit  = cur_word[5'(LAST_BIT - bit_pos - 5'd1)];
  assign show_bit  = led0_wire[LAST_BIT];
  assign adv_bit   = next_wire[LAST_BIT];

  always_comb begin
    phase_next    = phase;
    led_pos_next  = led_pos;
    bit_pos_next  = bit_pos;
    cnt_next      = cnt;
    line_reg_next = line_reg;
    cur_word_next = cur_word;
    if (acc) begin
      case (action)
        ACT_TICK: begin
          if (phase != PH_IDLE) begin
            cnt_next = cnt - 16'd1;
            if (cnt == 16'd1) begin
              case (phase)
                PH_HIGH: begin
                  phase_next    = PH_LOW;
                  line_reg_next = 1'b0;
                  cnt_next      = {8'd0, cur_bit ? at_least_one8(one_low_ticks)
                                                 : at_least_one8(zero_low_ticks)};
                end
                PH_LOW: begin
                  if (bit_pos < LAST_BIT) begin
                    bit_pos_next  = bit_pos + 5'd1;
                    phase_next    = PH_HIGH;
                    line_reg_next = 1'b1;
                    cnt_next      = {8'd0, next_bit ? at_least_one8(one_high_ticks)
                                                    : at_least_one8(zero_high_ticks)};
                  end else if (next_pos_ext < {1'b0, frame_leds}) begin
                    bit_pos_next  = '0;
                    led_pos_next  = led_pos + 1'b1;
                    cur_word_next = next_wire;
                    phase_next    = PH_HIGH;
                    line_reg_next = 1'b1;
                    cnt_next      = {8'd0, adv_bit ? at_least_one8(one_high_ticks)
                                                   : at_least_one8(zero_high_ticks)};
                  end else begin
                    bit_pos_next  = '0;
                    phase_next    = PH_LATCH;
                    line_reg_next = 1'b0;
                    cnt_next      = (latch_ticks == 16'd0) ? 16'd1 : latch_ticks;
                  end
                end
                default: begin
                  phase_next    = PH_IDLE;
                  line_reg_next = 1'b0;
                  led_pos_next  = '0;
                  bit_pos_next  = '0;
                end
              endcase
            end
          end
        end
        ACT_SHOW: begin
          if (phase == PH_IDLE) begin
            led_pos_next  = '0;
            bit_pos_next  = '0;
            cur_word_next = led0_wire;
            phase_next    = PH_HIGH;
            line_reg_next = 1'b1;
            cnt_next      = {8'd0, show_bit ? at_least_one8(one_high_ticks)
                                            : at_least_one8(zero_high_ticks)};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      led_pos   <= '0;
      bit_pos   <= '0;
      cnt       <= '0;
      line_reg  <= 1'b0;
      led0_word <= '0;
    end else begin
      phase    <= phase_next;
      led_pos  <= led_pos_next;
      bit_pos  <= bit_pos_next;
      cnt      <= cnt_next;
      line_reg <= line_reg_next;
      if (mem_we && (led_index == 6'd0)) begin
        led0_word <= {red, green, blue};
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_word <= cur_word_next;
  end

  assign res_in.line_level = line_reg_next;
  assign res_in.busy       = (phase_next != PH_IDLE);

  als_out_buf u_out (
    .clk(clk),
    .rst(rst),
    .push(acc),
    .push_data(res_in),
    .push_ready(buf_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(res_out)
  );

  assign line_level = res_out.line_level;
  assign busy_res   = res_out.busy;

  `ALS_ASSERT_NOW(a_no_write_busy, clk, rst, phase != PH_IDLE, !mem_we)
  `ALS_ASSERT_NOW(a_hold_in_clear, clk, rst, clr_busy, !in_ready)
  `ALS_ASSERT_NOW(a_line_high_phase, clk, rst, line_reg, phase == PH_HIGH)
  `ALS_ASSERT_NOW(a_count_live, clk, rst, phase != PH_IDLE, cnt != 16'd0)
  `ALS_ASSERT_NEXT(a_result_ready, clk, rst, acc, out_valid)

endmodule

// ===== verif/tb_addressable_led_serializer.sv =====
`timescale 1ns / 1ps

module tb_addressable_led_serializer;
  import als_pkg::*;

  localparam int N_LEDS = 64;
  localparam int MAX_GAP = 12;
  localparam int N_ROWS = 20;
  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam result_t OUT_IDLE = 2'b00;
  localparam result_t OUT_HIGH = 2'b11;
  localparam result_t OUT_LOW  = 2'b01;

  typedef struct packed {
    logic [1:0] act;
    logic [5:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       typed;
    result_t    want;
  } row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            action = ACT_TICK;
  logic [5:0]            led_index = '0;
  logic [7:0]            red = '0;
  logic [7:0]            green = '0;
  logic [7:0]            blue = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  line_level;
  logic                  busy_res;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  addressable_led_serializer u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .led_index(led_index),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .line_level(line_level), .busy_res(busy_res),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // line model state
  logic [23:0] pixel_mem [N_LEDS];
  logic [5:0]  led_pos;
  logic [4:0]  bit_pos;
  logic [15:0] phase_left;
  logic [1:0]  line_phase;
  logic        line_q;
  logic [7:0]  one_hi_t;
  logic [7:0]  one_lo_t;
  logic [7:0]  zero_hi_t;
  logic [7:0]  zero_lo_t;
  logic [15:0] latch_t;
  logic [6:0]  led_cnt;

  result_t level_q[$];
  row_t    dir_rows [N_ROWS];
  int      errors = 0;
  bit      gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] ticks_of(input logic [7:0] v);
    return (v == 8'd0) ? 16'd1 : {8'd0, v};
  endfunction

  function automatic logic sent_bit();
    logic [23:0] c;
    logic [23:0] w;
    c = pixel_mem[led_pos];
    w = {c[15:8], c[23:16], c[7:0]};
    return w[LAST_BIT - bit_pos];
  endfunction

  function automatic void start_high();
    line_phase = PH_HIGH;
    line_q = 1'b1;
    phase_left = sent_bit() ? ticks_of(one_hi_t) : ticks_of(zero_hi_t);
  endfunction

  function automatic void tick_line();
    int leds;
    leds = (led_cnt == 7'd0) ? 1 : ((led_cnt > N_LEDS) ? N_LEDS : int'(led_cnt));
    if (line_phase == PH_IDLE) return;
    phase_left = phase_left - 16'd1;
    if (phase_left != 16'd0) return;
    case (line_phase)
      PH_HIGH: begin
        line_phase = PH_LOW;
        line_q = 1'b0;
        phase_left = sent_bit() ? ticks_of(one_lo_t) : ticks_of(zero_lo_t);
      end
      PH_LOW: begin
        if (bit_pos < LAST_BIT) begin
          bit_pos = bit_pos + 5'd1;
          start_high();
        end else begin
          bit_pos = '0;
          if (int'(led_pos) + 1 < leds) begin
            led_pos = led_pos + 6'd1;
            start_high();
          end else begin
            line_phase = PH_LATCH;
            line_q = 1'b0;
            phase_left = (latch_t == 16'd0) ? 16'd1 : latch_t;
          end
        end
      end
      default: begin
        line_phase = PH_IDLE;
        line_q = 1'b0;
        led_pos = '0;
        bit_pos = '0;
      end
    endcase
  endfunction

  function automatic result_t apply_word(input logic [1:0] a, input logic [5:0] idx,
                                         input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    result_t res;
    logic    was_busy;
    was_busy = (line_phase != PH_IDLE);
    case (a)
      ACT_TICK: tick_line();
      ACT_WRITE: if (!was_busy) pixel_mem[idx] = {r, g, b};
      ACT_SHOW: if (!was_busy) begin
        led_pos = '0;
        bit_pos = '0;
        start_high();
      end
      default: ;
    endcase
    res.line_level = line_q;
    res.busy = (line_phase != PH_IDLE);
    return res;
  endfunction

  task automatic send_word(input logic [1:0] a, input logic [5:0] idx,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic typed, input result_t want);
    int      gap;
    result_t pred;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    led_index <= idx;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = apply_word(a, idx, r, g, b);
    level_q.push_back(typed ? want : pred);
  endtask

  task automatic send_random(input logic [1:0] a);
    send_word(a, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, OUT_IDLE);
  endtask

  task automatic drain_frame();
    while (line_phase != PH_IDLE) send_random(ACT_TICK);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_ONE_HIGH:  one_hi_t = data[7:0];
      REG_ONE_LOW:   one_lo_t = data[7:0];
      REG_ZERO_HIGH: zero_hi_t = data[7:0];
      REG_ZERO_LOW:  zero_lo_t = data[7:0];
      REG_LATCH:     latch_t = data;
      REG_LED_COUNT: led_cnt = data[6:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] oh, input logic [15:0] ol,
                              input logic [15:0] zh, input logic [15:0] zl,
                              input logic [15:0] lt, input logic [15:0] lc);
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    write_reg(REG_ONE_HIGH, oh);
    write_reg(REG_ONE_LOW, ol);
    write_reg(REG_ZERO_HIGH, zh);
    write_reg(REG_ZERO_LOW, zl);
    write_reg(REG_LATCH, lt);
    write_reg(REG_LED_COUNT, lc);
    write_reg(REG_SPARE_A, 16'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_B, 16'($urandom_range(0, 65535)));
    cfg_wen <= 1'b0;
  endtask

  task automatic frame_phase(input logic [15:0] oh, input logic [15:0] ol,
                             input logic [15:0] zh, input logic [15:0] zl,
                             input logic [15:0] lt, input logic [15:0] lc,
                             input bit drain_gaps);
    program_regs(oh, ol, zh, zl, lt, lc);
    gaps_on = 1'b1;
    repeat (6) send_random(ACT_WRITE);
    send_random(ACT_SHOW);
    gaps_on = drain_gaps;
    drain_frame();
  endtask

  task automatic random_burst(input int words);
    int         done;
    int         pick;
    logic [1:0] a;
    logic       was_busy;
    logic [5:0] idx;
    done = 0;
    while (done < words) begin
      was_busy = (line_phase != PH_IDLE);
      pick = $urandom_range(0, 99);
      if (was_busy)
        a = (pick < 88) ? ACT_TICK : (pick < 93) ? ACT_WRITE : (pick < 97) ? ACT_SHOW : ACT_NOP;
      else
        a = (pick < 50) ? ACT_WRITE : (pick < 75) ? ACT_SHOW : (pick < 90) ? ACT_TICK : ACT_NOP;
      if ((was_busy && a == ACT_TICK) || (!was_busy && (a == ACT_WRITE || a == ACT_SHOW)))
        done++;
      idx = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 3))
                                        : 6'($urandom_range(0, 63));
      send_word(a, idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'b0, OUT_IDLE);
    end
    drain_frame();
  endtask

  initial begin : sink
    int stall;
    @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (level_q.size() == 0) begin
        $display("%0t: word with none expected: line_level=%0b busy_res=%0b",
                 $time, line_level, busy_res);
        errors++;
      end else begin
        want = level_q.pop_front();
        if (line_level !== want.line_level) begin
          $display("%0t: line_level expected %0b actual %0b",
                   $time, want.line_level, line_level);
          errors++;
        end
        if (busy_res !== want.busy) begin
          $display("%0t: busy_res expected %0b actual %0b", $time, want.busy, busy_res);
          errors++;
        end
      end
    end
  end

  initial begin : stim
    foreach (pixel_mem[i]) pixel_mem[i] = '0;
    led_pos = '0;
    bit_pos = '0;
    phase_left = '0;
    line_phase = PH_IDLE;
    line_q = 1'b0;
    one_hi_t = 8'd11;
    one_lo_t = 8'd6;
    zero_hi_t = 8'd5;
    zero_lo_t = 8'd12;
    latch_t = 16'd960;
    led_cnt = 7'd64;

    dir_rows[0]  = {ACT_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, OUT_IDLE};
    dir_rows[1]  = {ACT_NOP,   6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b1, OUT_IDLE};
    dir_rows[2]  = {ACT_WRITE, 6'd0,  8'hFF, 8'h00, 8'hAA, 1'b1, OUT_IDLE};
    dir_rows[3]  = {ACT_WRITE, 6'd63, 8'h00, 8'hFF, 8'hFF, 1'b1, OUT_IDLE};
    dir_rows[4]  = {ACT_WRITE, 6'd1,  8'hFF, 8'hFF, 8'hFF, 1'b1, OUT_IDLE};
    dir_rows[5]  = {ACT_WRITE, 6'd42, 8'h55, 8'hA5, 8'h0F, 1'b1, OUT_IDLE};
    dir_rows[6]  = {ACT_WRITE, 6'd21, 8'hAA, 8'h5A, 8'hF0, 1'b1, OUT_IDLE};
    dir_rows[7]  = {ACT_TICK,  6'd21, 8'hFF, 8'hFF, 8'hFF, 1'b1, OUT_IDLE};
    dir_rows[8]  = {ACT_SHOW,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, OUT_HIGH};
    dir_rows[9]  = {ACT_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, OUT_HIGH};
    dir_rows[10] = {ACT_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, OUT_HIGH};
    dir_rows[11] = {ACT_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, OUT_HIGH};
    dir_rows[12] = {ACT_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, OUT_HIGH};
    dir_rows[13] = {ACT_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, OUT_LOW};
    dir_rows[14] = {ACT_WRITE, 6'd0,  8'hFF, 8'hFF, 8'hFF, 1'b0, OUT_IDLE};
    dir_rows[15] = {ACT_SHOW,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, OUT_IDLE};
    dir_rows[16] = {ACT_NOP,   6'd0,  8'h00, 8'h00, 8'h00, 1'b0, OUT_IDLE};
    dir_rows[17] = {ACT_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, OUT_IDLE};
    dir_rows[18] = {ACT_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, OUT_IDLE};
    dir_rows[19] = {ACT_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, OUT_IDLE};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // shorten the first frame; zero-bit high time keeps its reset value
    write_reg(REG_ONE_HIGH, 16'd2);
    write_reg(REG_ONE_LOW, 16'd1);
    write_reg(REG_ZERO_LOW, 16'd1);
    write_reg(REG_LATCH, 16'd2);
    write_reg(REG_LED_COUNT, 16'd1);
    cfg_wen <= 1'b0;

    foreach (dir_rows[i])
      send_word(dir_rows[i].act, dir_rows[i].idx, dir_rows[i].r, dir_rows[i].g,
                dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
    gaps_on = 1'b0;
    drain_frame();

    frame_phase(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 1'b0);
    frame_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    frame_phase(16'h0102, 16'hFF03, 16'h5501, 16'hAA02, 16'h0003, 16'hFF81, 1'b0);

    for (int k = 0; k < 2; k++) begin
      program_regs(16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                   16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                   16'($urandom_range(0, 4)), 16'($urandom_range(0, 1)));
      gaps_on = (k != 1);
      random_burst(45);
    end

    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/als_pkg.sv
src/als_frame_mem.sv
src/als_out_buf.sv
src/addressable_led_serializer.sv
verif/tb_addressable_led_serializer.sv
